// ===== design/scs_pkg.sv =====
// Shared types, constants and exponential table builder for the softmax classifier.
package scs_pkg;

    localparam int EXP_DEPTH = 256;
    localparam int EXP_LOG2  = 8;
    localparam int EXP_W     = 17;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASSES_IN_USE  = 2'd2;

    localparam logic [15:0] RATE_RESET = 16'd655;
    localparam logic [4:0]  NF_RESET   = 5'd16;
    localparam logic [3:0]  NC_RESET   = 4'd8;

    typedef logic [EXP_DEPTH:0][EXP_W-1:0] t_exp_tbl;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIAS,
        ST_BIAS_LD,
        ST_SCORE,
        ST_DRAIN,
        ST_LOGIT,
        ST_EXP_RD,
        ST_EXP_D,
        ST_EXP_MUL,
        ST_EXP_ACC,
        ST_DIV_RD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT,
        ST_UPD_RE,
        ST_UPD_BIAS,
        ST_UPD,
        ST_UPD_DRAIN
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic feat_wr;
        logic bias_rd;
        logic acc_init;
        logic mac_issue;
        logic logit_wr;
        logic logit_rd;
        logic exp_d;
        logic exp_mul;
        logic exp_acc;
        logic ev_rd;
        logic div_start;
        logic emit;
        logic last;
        logic target;
        logic re_calc;
        logic bias_wr;
        logic upd_issue;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

    // exp(-x) in Q1.30 by a series through the x^16 term, 0 <= x <= 1.0
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * x) >> 30) / 64'(k);
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_exp_tbl exp_table_build();
        t_exp_tbl    tbl;
        logic [63:0] e1;
        logic [63:0] a;
        logic [63:0] v;
        e1 = exp_neg_q30(ONE_Q30);
        for (int i = 0; i <= EXP_DEPTH; i++) begin
            a = ((64'(i) * 64'd16) << 30) / EXP_DEPTH;
            v = exp_neg_q30(a & (ONE_Q30 - 64'd1));
            for (int n = 0; n < int'(a >> 30); n++) begin
                v = (v * e1) >> 30;
            end
            tbl[i] = EXP_W'((v + 64'd8192) >> 14);
        end
        return tbl;
    endfunction

endpackage

// ===== design/scs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module scs_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_q[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_q    = i_num;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sub[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== design/scs_dp.sv =====
// Datapath: stores, MAC, exponential lookup, division and weight update.
module scs_dp #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_CLASSES  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  scs_pkg::t_dp_cmd      i_cmd,
    output scs_pkg::t_dp_sts      o_sts,
    input  logic [$clog2(MAX_CLASSES)-1:0] i_cls,
    input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] i_feat,
    input  logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] i_feat_wr_idx,
    input  logic [$clog2(MAX_CLASSES * MAX_FEATURES)-1:0] i_clr_addr,
    input  logic signed [15:0]    i_feature_value,
    input  logic [15:0]           i_learning_rate,
    output logic                  o_strobe,
    output logic [2:0]            o_class_index,
    output logic [15:0]           o_probability,
    output logic                  o_last_class
);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int TOTAL = MAX_CLASSES * MAX_FEATURES;
    localparam int WAW   = $clog2(TOTAL);
    localparam int ACC_W = 50 + $clog2(MAX_FEATURES + 1);
    localparam int SW    = 17 + CW;
    localparam int NW    = 34;
    localparam int EXP_LOG2_W = scs_pkg::EXP_LOG2;
    localparam scs_pkg::t_exp_tbl EXP_TBL = scs_pkg::exp_table_build();
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-64'sh8000_0000);
    localparam logic signed [33:0] W_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] W_MIN = -34'sh0_8000_0000;

    logic signed [31:0] weight_mem [TOTAL];
    logic signed [31:0] bias_mem   [MAX_CLASSES];
    logic signed [15:0] feat_mem   [MAX_FEATURES];
    logic signed [31:0] logit_mem  [MAX_CLASSES];
    logic [16:0]        ev_mem     [MAX_CLASSES];

    logic signed [31:0] r_w_rd, r_bias_rd, r_logit_rd;
    logic signed [15:0] r_x_rd;
    logic [16:0]        r_ev_rd;

    logic [WAW-1:0]     w_ra;
    logic               w_we;
    logic [WAW-1:0]     w_wa;
    logic signed [31:0] w_wd;
    logic               b_we;
    logic [CW-1:0]      b_wa;
    logic signed [31:0] b_wd;

    logic               r_mac_v1, r_mac_v2;
    logic signed [47:0] r_mprod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] acc_sh;
    logic signed [31:0] logit_val;
    logic signed [31:0] r_max;

    logic signed [32:0] r_d;
    logic               big;
    logic [EXP_LOG2_W-1:0] e_idx;
    logic [19:0]        e_frac;
    logic [16:0]        e_a, e_b, e_dif;
    logic [16:0]        r_ea;
    logic               r_edn, r_ebig;
    logic [36:0]        r_emul;
    logic [16:0]        ev_val;
    logic [SW-1:0]      r_sum;

    logic [NW-1:0]      div_num;
    logic [NW-1:0]      div_q;
    logic               div_done;
    logic [15:0]        p_sat;

    logic signed [17:0] err;
    logic signed [34:0] r_re;
    logic               r_upd_v1, r_upd_v2;
    logic [WAW-1:0]     r_wa1, r_wa2;
    logic signed [50:0] r_uprod;
    logic signed [31:0] r_wq;
    logic signed [50:0] upd_rnd;
    logic signed [33:0] w_sum;
    logic signed [35:0] b_rnd;
    logic signed [33:0] b_sum;
    logic [CW+2:0]      cls_ext;

    logic        r_strobe;
    logic [2:0]  r_cls_out;
    logic [15:0] r_prob;
    logic        r_last;

    always_comb begin
        w_ra = WAW'(int'(i_cls) * MAX_FEATURES + int'(i_feat));
    end

    // MAC result scaling and logit saturation
    always_comb begin
        acc_sh = r_acc >>> 12;
        if (acc_sh > ACC_MAX) begin
            logit_val = 32'sh7FFF_FFFF;
        end else if (acc_sh < ACC_MIN) begin
            logit_val = -32'sh8000_0000;
        end else begin
            logit_val = 32'(acc_sh);
        end
    end

    // exponential lookup with interpolation
    always_comb begin
        big    = |r_d[32:20];
        e_idx  = r_d[19 -: EXP_LOG2_W];
        e_frac = {r_d[19-EXP_LOG2_W:0], EXP_LOG2_W'(0)};
        e_a    = EXP_TBL[e_idx];
        e_b    = EXP_TBL[{1'b0, e_idx} + 1'b1];
        e_dif  = (e_a >= e_b) ? (e_a - e_b) : (e_b - e_a);
        if (r_ebig) begin
            ev_val = '0;
        end else if (r_edn) begin
            ev_val = r_ea - 17'(r_emul >> 20);
        end else begin
            ev_val = r_ea + 17'(r_emul >> 20);
        end
    end

    always_comb begin
        div_num = {r_ev_rd, 16'd0} + NW'(r_sum >> 1);
        if (r_sum == '0) begin
            p_sat = '0;
        end else if (div_q > NW'(65535)) begin
            p_sat = 16'hFFFF;
        end else begin
            p_sat = div_q[15:0];
        end
        err = (i_cmd.target ? 18'sd65536 : 18'sd0) - $signed({2'b00, p_sat});
    end

    // weight and bias update arithmetic
    always_comb begin
        upd_rnd = (r_uprod + 51'sd134217728) >>> 28;
        w_sum   = 34'(r_wq) + 34'(upd_rnd);
        b_rnd   = (36'(r_re) + 36'sd32768) >>> 16;
        b_sum   = 34'(r_bias_rd) + 34'(b_rnd);
        if (i_cmd.clr_wr) begin
            w_we = 1'b1;
            w_wa = i_clr_addr;
            w_wd = '0;
        end else begin
            w_we = r_upd_v2;
            w_wa = r_wa2;
            if (w_sum > W_MAX) begin
                w_wd = 32'sh7FFF_FFFF;
            end else if (w_sum < W_MIN) begin
                w_wd = -32'sh8000_0000;
            end else begin
                w_wd = 32'(w_sum);
            end
        end
        if (i_cmd.clr_wr) begin
            b_we = int'(i_clr_addr) < MAX_CLASSES;
            b_wa = i_clr_addr[CW-1:0];
            b_wd = '0;
        end else begin
            b_we = i_cmd.bias_wr;
            b_wa = i_cls;
            if (b_sum > W_MAX) begin
                b_wd = 32'sh7FFF_FFFF;
            end else if (b_sum < W_MIN) begin
                b_wd = -32'sh8000_0000;
            end else begin
                b_wd = 32'(b_sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            weight_mem[w_wa] <= w_wd;
        end
        r_w_rd <= weight_mem[w_ra];
        if (b_we) begin
            bias_mem[b_wa] <= b_wd;
        end
        if (i_cmd.bias_rd) begin
            r_bias_rd <= bias_mem[i_cls];
        end
        if (i_cmd.feat_wr) begin
            feat_mem[i_feat_wr_idx] <= i_feature_value;
        end
        r_x_rd <= feat_mem[i_feat];
        if (i_cmd.logit_wr) begin
            logit_mem[i_cls] <= logit_val;
        end
        if (i_cmd.logit_rd) begin
            r_logit_rd <= logit_mem[i_cls];
        end
        if (i_cmd.exp_acc) begin
            ev_mem[i_cls] <= ev_val;
        end
        if (i_cmd.ev_rd) begin
            r_ev_rd <= ev_mem[i_cls];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_v1 <= 1'b0;
            r_mac_v2 <= 1'b0;
            r_upd_v1 <= 1'b0;
            r_upd_v2 <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_mac_v1 <= i_cmd.mac_issue;
            r_mac_v2 <= r_mac_v1;
            r_upd_v1 <= i_cmd.upd_issue;
            r_upd_v2 <= r_upd_v1;
            r_strobe <= i_cmd.emit;
        end
        r_mprod <= r_w_rd * r_x_rd;
        if (i_cmd.acc_init) begin
            r_acc <= ACC_W'(r_bias_rd) <<< 12;
        end else if (r_mac_v2) begin
            r_acc <= r_acc + ACC_W'(r_mprod);
        end
        if (i_cmd.logit_wr && ((i_cls == '0) || (logit_val > r_max))) begin
            r_max <= logit_val;
        end
        if (i_cmd.exp_d) begin
            r_d <= 33'(r_max) - 33'(r_logit_rd);
        end
        if (i_cmd.exp_mul) begin
            r_ea   <= e_a;
            r_edn  <= e_a >= e_b;
            r_ebig <= big;
            r_emul <= 37'(e_dif) * 37'(e_frac);
        end
        if (i_cmd.exp_acc) begin
            r_sum <= (i_cls == '0) ? SW'(ev_val) : r_sum + SW'(ev_val);
        end
        if (i_cmd.re_calc) begin
            r_re <= 35'($signed({1'b0, i_learning_rate})) * 35'(err);
        end
        r_wa1   <= w_ra;
        r_wa2   <= r_wa1;
        r_uprod <= 51'(r_re) * 51'(r_x_rd);
        r_wq    <= r_w_rd;
        if (i_cmd.emit) begin
            r_cls_out <= cls_ext[2:0];
            r_prob    <= p_sat;
            r_last    <= i_cmd.last;
        end
    end

    assign cls_ext = (CW + 3)'(i_cls);

    scs_div #(
        .NUM_W (NW),
        .DEN_W (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign o_sts.div_done = div_done;
    assign o_strobe       = r_strobe;
    assign o_class_index  = r_cls_out;
    assign o_probability  = r_prob;
    assign o_last_class   = r_last;
endmodule

// ===== design/scs_ctrl.sv =====
// Controller: sample sequencing, clearing pass and per-class loops.
module scs_ctrl #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_CLASSES  = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_mode,
    input  logic [2:0]        i_true_label,
    input  logic [$clog2(MAX_FEATURES + 1)-1:0] i_nf,
    input  logic [$clog2(MAX_CLASSES + 1)-1:0]  i_nc,
    input  scs_pkg::t_dp_sts  i_sts,
    output scs_pkg::t_dp_cmd  o_cmd,
    output logic [$clog2(MAX_CLASSES)-1:0] o_cls,
    output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] o_feat,
    output logic [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] o_feat_wr_idx,
    output logic [$clog2(MAX_CLASSES * MAX_FEATURES)-1:0] o_clr_addr,
    output logic              o_busy
);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int NCW   = $clog2(MAX_CLASSES + 1);
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FCW   = $clog2(MAX_FEATURES + 1);
    localparam int TOTAL = MAX_CLASSES * MAX_FEATURES;
    localparam int WAW   = $clog2(TOTAL);

    scs_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cls, n_cls;
    logic [FW-1:0]   r_feat, n_feat;
    logic [FCW-1:0]  r_fcnt, n_fcnt;
    logic [WAW-1:0]  r_clr, n_clr;
    logic            r_drain, n_drain;
    logic            r_train, n_train;
    logic [2:0]      r_label, n_label;
    logic            last_cls;
    logic            last_feat;
    logic [FCW:0]    fcnt_inc;

    always_comb begin
        last_cls  = ((NCW + 1)'(r_cls) + 1'b1) == (NCW + 1)'(i_nc);
        last_feat = ((FCW + 1)'(r_feat) + 1'b1) == (FCW + 1)'(i_nf);
        fcnt_inc  = (FCW + 1)'(r_fcnt) + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        n_cls   = r_cls;
        n_feat  = r_feat;
        n_fcnt  = r_fcnt;
        n_clr   = r_clr;
        n_drain = r_drain;
        n_train = r_train;
        n_label = r_label;
        o_cmd   = '0;
        o_cmd.last   = last_cls;
        o_cmd.target = ((CW + 3)'(r_label) == (CW + 3)'(r_cls));
        unique case (r_state)
            scs_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == WAW'(TOTAL - 1)) begin
                    n_state = scs_pkg::ST_IDLE;
                end
            end
            scs_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.feat_wr = int'(r_fcnt) < MAX_FEATURES;
                    n_fcnt = FCW'(fcnt_inc);
                    if (fcnt_inc >= (FCW + 1)'(i_nf)) begin
                        n_fcnt  = '0;
                        n_train = i_mode;
                        n_label = i_true_label;
                        n_cls   = '0;
                        n_state = scs_pkg::ST_BIAS;
                    end
                end
            end
            scs_pkg::ST_BIAS: begin
                o_cmd.bias_rd = 1'b1;
                n_state = scs_pkg::ST_BIAS_LD;
            end
            scs_pkg::ST_BIAS_LD: begin
                o_cmd.acc_init = 1'b1;
                n_feat  = '0;
                n_state = scs_pkg::ST_SCORE;
            end
            scs_pkg::ST_SCORE: begin
                o_cmd.mac_issue = 1'b1;
                n_feat = r_feat + 1'b1;
                if (last_feat) begin
                    n_drain = 1'b0;
                    n_state = scs_pkg::ST_DRAIN;
                end
            end
            scs_pkg::ST_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = scs_pkg::ST_LOGIT;
                end
            end
            scs_pkg::ST_LOGIT: begin
                o_cmd.logit_wr = 1'b1;
                if (last_cls) begin
                    n_cls   = '0;
                    n_state = scs_pkg::ST_EXP_RD;
                end else begin
                    n_cls   = r_cls + 1'b1;
                    n_state = scs_pkg::ST_BIAS;
                end
            end
            scs_pkg::ST_EXP_RD: begin
                o_cmd.logit_rd = 1'b1;
                n_state = scs_pkg::ST_EXP_D;
            end
            scs_pkg::ST_EXP_D: begin
                o_cmd.exp_d = 1'b1;
                n_state = scs_pkg::ST_EXP_MUL;
            end
            scs_pkg::ST_EXP_MUL: begin
                o_cmd.exp_mul = 1'b1;
                n_state = scs_pkg::ST_EXP_ACC;
            end
            scs_pkg::ST_EXP_ACC: begin
                o_cmd.exp_acc = 1'b1;
                if (last_cls) begin
                    n_cls   = '0;
                    n_state = scs_pkg::ST_DIV_RD;
                end else begin
                    n_cls   = r_cls + 1'b1;
                    n_state = scs_pkg::ST_EXP_RD;
                end
            end
            scs_pkg::ST_DIV_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state = scs_pkg::ST_DIV_GO;
            end
            scs_pkg::ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = scs_pkg::ST_DIV_WAIT;
            end
            scs_pkg::ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = r_train ? scs_pkg::ST_UPD_RE : scs_pkg::ST_EMIT;
                end
            end
            scs_pkg::ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (last_cls) begin
                    n_state = scs_pkg::ST_IDLE;
                end else begin
                    n_cls   = r_cls + 1'b1;
                    n_state = scs_pkg::ST_DIV_RD;
                end
            end
            scs_pkg::ST_UPD_RE: begin
                o_cmd.re_calc = 1'b1;
                o_cmd.bias_rd = 1'b1;
                n_state = scs_pkg::ST_UPD_BIAS;
            end
            scs_pkg::ST_UPD_BIAS: begin
                o_cmd.bias_wr = 1'b1;
                n_feat  = '0;
                n_state = scs_pkg::ST_UPD;
            end
            scs_pkg::ST_UPD: begin
                o_cmd.upd_issue = 1'b1;
                n_feat = r_feat + 1'b1;
                if (last_feat) begin
                    n_drain = 1'b0;
                    n_state = scs_pkg::ST_UPD_DRAIN;
                end
            end
            scs_pkg::ST_UPD_DRAIN: begin
                n_drain = 1'b1;
                // hold until the last write-back lands
                if (r_drain) begin
                    if (last_cls) begin
                        n_state = scs_pkg::ST_IDLE;
                    end else begin
                        n_cls   = r_cls + 1'b1;
                        n_state = scs_pkg::ST_DIV_RD;
                    end
                end
            end
            default: begin
                n_state = scs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scs_pkg::ST_CLEAR;
            r_cls   <= '0;
            r_feat  <= '0;
            r_fcnt  <= '0;
            r_clr   <= '0;
            r_drain <= 1'b0;
            r_train <= 1'b0;
            r_label <= '0;
        end else begin
            r_state <= n_state;
            r_cls   <= n_cls;
            r_feat  <= n_feat;
            r_fcnt  <= n_fcnt;
            r_clr   <= n_clr;
            r_drain <= n_drain;
            r_train <= n_train;
            r_label <= n_label;
        end
    end

    assign o_cls         = r_cls;
    assign o_feat        = r_feat;
    assign o_feat_wr_idx = r_fcnt[FW-1:0];
    assign o_clr_addr    = r_clr;
    assign o_busy        = r_state != scs_pkg::ST_IDLE;
endmodule

// ===== design/softmax_classifier_sgd.sv =====
// Top level: softmax classifier with online gradient-descent training.
//
//  Channel   Handshake               Payload
//  request   start, busy             i_mode, i_feature_value, i_true_label
//  result    o_strobe (one cycle)    o_class_index, o_probability, o_last_class
//  config    i_cfg_we                i_cfg_index, i_cfg_data
//
// A feature request that does not complete a sample is stored at once, busy
// staying low. A completing request is scored class by class, its
// exponentials are formed, then each class runs through the shared serial
// divider and, in training, the weight update loop, with busy high.
// After reset a clearing pass over every weight address zeroes the
// weight and bias stores with busy high. Results cannot be stalled.
module softmax_classifier_sgd #(
    parameter int MAX_FEATURES = 16,
    parameter int MAX_CLASSES  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [15:0] i_feature_value,
    input  logic [2:0]  i_true_label,
    input  logic        i_cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_class_index,
    output logic [15:0] o_probability,
    output logic        o_last_class
);
    localparam int CW    = $clog2(MAX_CLASSES);
    localparam int NCW   = $clog2(MAX_CLASSES + 1);
    localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FCW   = $clog2(MAX_FEATURES + 1);
    localparam int WAW   = $clog2(MAX_CLASSES * MAX_FEATURES);

    logic [15:0]      r_rate;
    logic [4:0]       r_nf;
    logic [3:0]       r_nc;
    logic [FCW-1:0]   nf;
    logic [NCW-1:0]   nc;
    scs_pkg::t_dp_cmd cmd;
    scs_pkg::t_dp_sts sts;
    logic [CW-1:0]    cls;
    logic [FW-1:0]    feat;
    logic [FW-1:0]    feat_wr_idx;
    logic [WAW-1:0]   clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= scs_pkg::RATE_RESET;
            r_nf   <= scs_pkg::NF_RESET;
            r_nc   <= scs_pkg::NC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scs_pkg::REG_LEARNING_RATE:   r_rate <= i_cfg_data;
                scs_pkg::REG_FEATURES_IN_USE: r_nf   <= i_cfg_data[4:0];
                scs_pkg::REG_CLASSES_IN_USE:  r_nc   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // clamp counts into the supported range
    always_comb begin
        if (r_nf == '0) begin
            nf = FCW'(1);
        end else if (int'(r_nf) > MAX_FEATURES) begin
            nf = FCW'(MAX_FEATURES);
        end else begin
            nf = FCW'(r_nf);
        end
        if (r_nc == '0) begin
            nc = NCW'(1);
        end else if (int'(r_nc) > MAX_CLASSES) begin
            nc = NCW'(MAX_CLASSES);
        end else begin
            nc = NCW'(r_nc);
        end
    end

    scs_ctrl #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_mode        (i_mode),
        .i_true_label  (i_true_label),
        .i_nf          (nf),
        .i_nc          (nc),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_cls         (cls),
        .o_feat        (feat),
        .o_feat_wr_idx (feat_wr_idx),
        .o_clr_addr    (clr_addr),
        .o_busy        (busy)
    );

    scs_dp #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_CLASSES  (MAX_CLASSES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cls           (cls),
        .i_feat          (feat),
        .i_feat_wr_idx   (feat_wr_idx),
        .i_clr_addr      (clr_addr),
        .i_feature_value ($signed(i_feature_value)),
        .i_learning_rate (r_rate),
        .o_strobe        (o_strobe),
        .o_class_index   (o_class_index),
        .o_probability   (o_probability),
        .o_last_class    (o_last_class)
    );
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the softmax classifier: directed table, then random samples.
module tb_top;
    import scs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFEAT          = 16;
    localparam int NCLS           = 8;
    localparam int TBL_DEPTH      = 256;
    localparam int SETTLE_CYCLES  = 900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int ITEMS_PER_PASS = 50;
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_TRAIN   = 1'b1;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  mode;
        logic [15:0]           feature;
        logic [2:0]            label;
        int                    known_prob;   // -1: take the predictor's value
    } t_plan_row;

    typedef struct {
        logic [2:0]  cls;
        logic [15:0] prob;
        logic        last;
    } t_score;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_mode = 1'b0;
    logic [15:0]           i_feature_value = '0;
    logic [2:0]            i_true_label = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_strobe;
    logic [2:0]            o_class_index;
    logic [15:0]           o_probability;
    logic                  o_last_class;

    softmax_classifier_sgd dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_feature_value(i_feature_value),
        .i_true_label   (i_true_label),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_class_index  (o_class_index),
        .o_probability  (o_probability),
        .o_last_class   (o_last_class)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [63:0] exp_lut [0:TBL_DEPTH];
    int          weights [NCLS*NFEAT];
    int          biases [NCLS];
    int          feat_buf [NFEAT];
    int          feat_count;
    logic [15:0] rate_reg;
    logic [4:0]  nf_reg;
    logic [3:0]  nc_reg;

    t_score expected_scores [$];
    int     mismatches;
    int     idle_cycles;
    bit     out_of_reset;

    function automatic logic [63:0] series_exp_neg(input logic [63:0] x);
        logic [63:0] acc;
        logic [63:0] term;
        acc  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            term = ((term * x) >> 30) / 64'(k);
            acc  = (k % 2) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    task automatic fill_exp_lut();
        logic [63:0] e_one;
        logic [63:0] arg;
        logic [63:0] v;
        e_one = series_exp_neg(64'd1 << 30);
        for (int i = 0; i <= TBL_DEPTH; i++) begin
            arg = ((64'(i) * 64'd16) << 30) / TBL_DEPTH;
            v = series_exp_neg(arg & ((64'd1 << 30) - 1));
            for (int n = 0; n < int'(arg >> 30); n++) v = (v * e_one) >> 30;
            exp_lut[i] = (v + 64'd8192) >> 14;
        end
    endtask

    function automatic int clip32(input longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(64'sh80000000)) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic logic [63:0] interp_exp(input logic [63:0] d);
        logic [63:0] pos;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] frac;
        if (d >= (64'd16 << 16)) return 64'd0;
        pos  = d * TBL_DEPTH;
        frac = pos & 64'hFFFFF;
        lo   = exp_lut[pos >> 20];
        hi   = exp_lut[(pos >> 20) + 1];
        if (lo >= hi) return lo - (((lo - hi) * frac) >> 20);
        return lo + (((hi - lo) * frac) >> 20);
    endfunction

    // Advance the predictor by one accepted request; queue predicted scores.
    task automatic classify_step(input logic mode, input logic [15:0] feature,
                                 input logic [2:0] label, input int known_prob);
        int          nf;
        int          nc;
        longint      acc;
        longint      maxl;
        longint      err;
        longint      re;
        int          logit [NCLS];
        logic [63:0] ev [NCLS];
        logic [63:0] total;
        logic [63:0] p;
        longint      prob [NCLS];
        t_score      s;
        nf = (nf_reg < 1) ? 1 : (nf_reg > NFEAT) ? NFEAT : int'(nf_reg);
        nc = (nc_reg < 1) ? 1 : (nc_reg > NCLS) ? NCLS : int'(nc_reg);
        if (feat_count < NFEAT) feat_buf[feat_count] = int'($signed(feature));
        feat_count++;
        if (feat_count < nf) return;
        feat_count = 0;
        for (int c = 0; c < nc; c++) begin
            acc = longint'(biases[c]) * 4096;
            for (int f = 0; f < nf; f++)
                acc += longint'(weights[c*NFEAT+f]) * longint'(feat_buf[f]);
            logit[c] = clip32(acc >>> 12);
        end
        maxl = logit[0];
        for (int c = 1; c < nc; c++) if (logit[c] > maxl) maxl = logit[c];
        total = 0;
        for (int c = 0; c < nc; c++) begin
            ev[c] = interp_exp(64'(maxl - longint'(logit[c])));
            total += ev[c];
        end
        for (int c = 0; c < nc; c++) begin
            p = (total != 0) ? ((ev[c] << 16) + total / 2) / total : 64'd0;
            prob[c] = (p > 64'd65535) ? 65535 : longint'(p);
        end
        if (mode == MODE_PREDICT) begin
            for (int c = 0; c < nc; c++) begin
                s.cls  = 3'(c);
                s.prob = (known_prob >= 0) ? 16'(known_prob) : 16'(prob[c]);
                s.last = (c + 1 == nc);
                expected_scores.insert(expected_scores.size(), s);
            end
            return;
        end
        for (int c = 0; c < nc; c++) begin
            err = ((c == int'(label)) ? 65536 : 0) - prob[c];
            re  = longint'(rate_reg) * err;
            for (int f = 0; f < nf; f++)
                weights[c*NFEAT+f] = clip32(longint'(weights[c*NFEAT+f]) +
                    ((re * longint'(feat_buf[f]) + (longint'(1) << 27)) >>> 28));
            biases[c] = clip32(longint'(biases[c]) + ((re + 32768) >>> 16));
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Score checker
    always @(posedge i_clk) begin
        t_score want;
        if (out_of_reset && o_strobe) begin
            if (expected_scores.size() == 0) begin
                flag_mismatch("unexpected score, class", o_class_index, -1);
            end else begin
                want = expected_scores.pop_front();
                if (o_class_index !== want.cls)
                    flag_mismatch("class_index", o_class_index, want.cls);
                if (o_probability !== want.prob)
                    flag_mismatch("probability", o_probability, want.prob);
                if (o_last_class !== want.last)
                    flag_mismatch("last_class", o_last_class, want.last);
            end
        end
    end

    // Watchdog on cycles with no request and no score accepted
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (expected_scores.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        start <= 1'b0;
        wait_drained();
        // training samples give no scores: let any update loop finish
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LEARNING_RATE:   rate_reg = val;
            REG_FEATURES_IN_USE: nf_reg = val[4:0];
            REG_CLASSES_IN_USE:  nc_reg = val[3:0];
            default: ;
        endcase
    endtask

    task automatic send_request(input logic mode, input logic [15:0] feature,
                                input logic [2:0] label, input int idle_pct,
                                input int known_prob);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_mode          <= mode;
        i_feature_value <= feature;
        i_true_label    <= label;
        do @(posedge i_clk); while (busy);
        classify_step(mode, feature, label, known_prob);
    endtask

    function automatic t_plan_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r = '{ROW_CFG, idx, val, MODE_PREDICT, 16'h0, 3'd0, -1};
        return r;
    endfunction

    function automatic t_plan_row req_row(input logic mode, input logic [15:0] feature,
                                          input logic [2:0] label, input int known);
        t_plan_row r;
        r = '{ROW_ITEM, REG_LEARNING_RATE, 16'h0, mode, feature, label, known};
        return r;
    endfunction

    function automatic logic [15:0] random_feature();
        if ($urandom_range(1)) return 16'($urandom_range(65535));
        return 16'($urandom_range(8191) - 4096);
    endfunction

    initial begin
        t_plan_row plan [$];
        int        pass_idle [4];
        int        sent;
        int        nf;
        int        sample_no;
        logic      mode;
        logic [2:0] label;

        fill_exp_lut();
        foreach (weights[i]) weights[i] = 0;
        foreach (biases[i]) biases[i] = 0;
        foreach (feat_buf[i]) feat_buf[i] = 0;
        feat_count   = 0;
        rate_reg     = RATE_RESET;
        nf_reg       = NF_RESET;
        nc_reg       = NC_RESET;
        mismatches   = 0;
        idle_cycles  = 0;
        out_of_reset = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        out_of_reset = 1;

        plan = '{
            // untrained: all classes equal
            cfg_row(REG_FEATURES_IN_USE, 16'd1),
            req_row(MODE_PREDICT, 16'h7fff, 3'd0, 8192),
            req_row(MODE_PREDICT, 16'h8000, 3'd0, 8192),
            // a single class saturates
            cfg_row(REG_CLASSES_IN_USE, 16'd1),
            req_row(MODE_PREDICT, 16'h1234, 3'd0, 65535),
            cfg_row(REG_CLASSES_IN_USE, 16'd2),
            req_row(MODE_TRAIN, 16'h7fff, 3'd0, -1),
            req_row(MODE_TRAIN, 16'h8000, 3'd1, -1),
            // label beyond the classes in use: all-zero target
            req_row(MODE_TRAIN, 16'h1000, 3'd7, -1),
            req_row(MODE_PREDICT, 16'h1000, 3'd0, -1),
            cfg_row(REG_LEARNING_RATE, 16'hffff),
            req_row(MODE_TRAIN, 16'h7fff, 3'd1, -1),
            req_row(MODE_TRAIN, 16'h7fff, 3'd1, -1),
            req_row(MODE_PREDICT, 16'h7fff, 3'd0, -1),
            cfg_row(REG_LEARNING_RATE, 16'h0),
            req_row(MODE_TRAIN, 16'h8000, 3'd0, -1),
            // zero feature count clamps to one
            cfg_row(REG_FEATURES_IN_USE, 16'd0),
            req_row(MODE_PREDICT, 16'hc000, 3'd0, -1),
            // shrink the count while a sample is half in
            cfg_row(REG_FEATURES_IN_USE, 16'd3),
            req_row(MODE_PREDICT, 16'h0800, 3'd0, -1),
            req_row(MODE_PREDICT, 16'hf800, 3'd0, -1),
            cfg_row(REG_FEATURES_IN_USE, 16'd2),
            req_row(MODE_PREDICT, 16'h4000, 3'd0, -1),
            // out-of-range class counts clamp
            cfg_row(REG_CLASSES_IN_USE, 16'd0),
            req_row(MODE_PREDICT, 16'h0001, 3'd0, 65535),
            req_row(MODE_PREDICT, 16'h0002, 3'd0, 65535),
            cfg_row(REG_CLASSES_IN_USE, 16'd15),
            req_row(MODE_PREDICT, 16'h2000, 3'd0, -1),
            req_row(MODE_PREDICT, 16'he000, 3'd0, -1)
        };
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_request(plan[i].mode, plan[i].feature, plan[i].label, 0,
                             plan[i].known_prob);
        end

        pass_idle = '{0, 65, 0, 29};
        sample_no = 0;
        foreach (pass_idle[ph]) begin
            case ($urandom_range(3))
                0: write_reg(REG_LEARNING_RATE, 16'hffff);
                1: write_reg(REG_LEARNING_RATE, 16'h0);
                default: write_reg(REG_LEARNING_RATE, 16'($urandom_range(65535)));
            endcase
            case ($urandom_range(9))
                0: nf = 0;
                1: nf = 16;
                2: nf = $urandom_range(17, 31);
                default: nf = $urandom_range(1, 4);
            endcase
            write_reg(REG_FEATURES_IN_USE, 16'(nf));
            write_reg(REG_CLASSES_IN_USE, (ph == 0) ? 16'd8 : 16'($urandom_range(15)));
            sent = 0;
            while (sent < ITEMS_PER_PASS) begin
                // train most samples so the weights move, predict the rest
                mode  = ($urandom_range(99) < 60) ? MODE_TRAIN : MODE_PREDICT;
                label = 3'($urandom_range(7));
                sample_no++;
                if (sample_no % 10 == 3) begin
                    start <= 1'b0;
                    wait_drained();
                end
                for (int k = 0; k < ((nf < 1) ? 1 : (nf > 16) ? 16 : nf); k++) begin
                    send_request(mode, random_feature(), label, pass_idle[ph], -1);
                    sent++;
                end
            end
            start <= 1'b0;
        end

        start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_scores.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
